@@ rtl/cms_pkg.sv @@
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, codes and helpers of the cube map nearest texel sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

    // Request kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_FACE  = 2'd1,
        MODE_CUBE  = 2'd2
    } mode_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_FACE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FACE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_ADDRESS_MODE = 2'd2;

    localparam logic [6:0] FACE_WIDTH_RESET  = 7'd64;
    localparam logic [6:0] FACE_HEIGHT_RESET = 7'd64;

    // Face coordinate quotient: 17 bits, one bit resolved per divider step.
    localparam int DIV_STEPS = 17;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    // Request data that travels alongside the coordinate math.
    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  face;
        logic [11:0] texel_index;
        logic [31:0] texel_data;
        logic [16:0] cu;
        logic [16:0] cv;
        logic        zero_dir;
    } side_t;

    // Brings a coordinate to [0,65536]: repeat keeps the fraction, clamp saturates.
    function automatic logic [16:0] addr_coord(input logic signed [33:0] c,
                                               input logic clamp);
        logic [16:0] res;
        if (clamp) begin
            if (c < 0) begin
                res = '0;
            end else if (c > 34'sd65536) begin
                res = ONE_Q16;
            end else begin
                res = c[16:0];
            end
        end else begin
            res = {1'b0, c[15:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cubemap_nearest_texture_sampler.sv @@
// ----------------------------------------------------------------------------
// cubemap_nearest_texture_sampler
// Six-face RGBA8 texel store with nearest 2D and cube direction sampling.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_axis_tvalid/tready      tuser: mode; tdata: request
// m_axis    out        m_axis_tvalid/tready      tdata: one sampled texel
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One request is taken every cycle unless the pipeline holds. A sample
// request passes through the input register, face selection, offset add,
// a 17 step divider pipeline, address mode, column/row multiply, index
// multiply-add, the memory read cycle and the output register. The
// divider pipeline sets the latency. Writes take effect in the memory
// cycle in request order, so a later sample always sees an earlier write.
// Reset clears only control state; the texel store is not cleared. The
// whole pipeline holds only while a finished texel waits in the output
// register and another one is ready behind it.
//
`default_nettype none

module cubemap_nearest_texture_sampler #(
    parameter int MAX_SIDE   = 64,
    parameter int FACE_COUNT = 6
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Request stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [1:0] mode
    input  wire logic [1:0]   s_axis_tuser,
    // [2:0] face, [14:3] texel_index, [46:15] texel_data, [78:47] coord_u,
    // [110:79] coord_v, [142:111] dir_x, [174:143] dir_y, [206:175] dir_z,
    // [207] zero
    input  wire logic [207:0] s_axis_tdata,
    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] sampled_texel, [34:32] face_used, [46:35] index_used, [47] zero
    output logic [47:0]       m_axis_tdata,
    // Configuration writes.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [6:0]   cfg_data
);

    // Derived sizes.
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AREA  = MAX_SIDE * MAX_SIDE;
    localparam int IW    = (AREA > 1) ? $clog2(AREA) : 1;
    localparam int DEPTH = FACE_COUNT * AREA;
    localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes
    // are dropped.
    // ------------------------------------------------------------------
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    logic       clamp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cms_pkg::FACE_WIDTH_RESET;
            height_reg <= cms_pkg::FACE_HEIGHT_RESET;
            clamp_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cms_pkg::REG_FACE_WIDTH:   width_reg  <= cfg_data;
                cms_pkg::REG_FACE_HEIGHT:  height_reg <= cfg_data;
                cms_pkg::REG_ADDRESS_MODE: clamp_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, sizes above the store side act as its side.
    logic [SW-1:0] weff;
    logic [SW-1:0] heff;

    always_comb
    begin
        if (width_reg == 7'd0)
            weff = SW'(1);
        else if (32'(width_reg) > 32'(MAX_SIDE))
            weff = SW'(MAX_SIDE);
        else
            weff = SW'(width_reg);
        if (height_reg == 7'd0)
            heff = SW'(1);
        else if (32'(height_reg) > 32'(MAX_SIDE))
            heff = SW'(MAX_SIDE);
        else
            heff = SW'(height_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Everything moves together unless a texel sits in
    // the memory stage while the output register is full and stalled.
    // ------------------------------------------------------------------
    logic en;
    logic g_valid_reg;
    logic out_valid_reg;

    assign en            = !g_valid_reg || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage A: request register. Unknown request kinds are dropped here.
    // ------------------------------------------------------------------
    logic        a_valid_reg;
    logic        a_valid_next;
    logic [1:0]  a_mode_reg;
    logic [2:0]  a_face_reg;
    logic [11:0] a_idx_reg;
    logic [31:0] a_data_reg;
    logic [31:0] a_u_reg;
    logic [31:0] a_v_reg;
    logic [31:0] a_x_reg;
    logic [31:0] a_y_reg;
    logic [31:0] a_z_reg;

    assign a_valid_next = s_axis_tvalid &&
                          (s_axis_tuser == cms_pkg::MODE_WRITE ||
                           s_axis_tuser == cms_pkg::MODE_FACE  ||
                           s_axis_tuser == cms_pkg::MODE_CUBE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg <= s_axis_tuser;
            a_face_reg <= s_axis_tdata[2:0];
            a_idx_reg  <= s_axis_tdata[14:3];
            a_data_reg <= s_axis_tdata[46:15];
            a_u_reg    <= s_axis_tdata[78:47];
            a_v_reg    <= s_axis_tdata[110:79];
            a_x_reg    <= s_axis_tdata[142:111];
            a_y_reg    <= s_axis_tdata[174:143];
            a_z_reg    <= s_axis_tdata[206:175];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: major axis and face selection. Ties go to y over x and to
    // z over both; a component of zero counts as negative.
    // ------------------------------------------------------------------
    logic [31:0]    ax;
    logic [31:0]    ay;
    logic [31:0]    az;
    logic [32:0]    xs;
    logic [32:0]    ys;
    logic [32:0]    zs;
    logic [32:0]    xn;
    logic [32:0]    yn;
    logic [32:0]    zn;
    logic [2:0]     cube_face;
    logic [31:0]    ma_next;
    logic [32:0]    sc_next;
    logic [32:0]    tc_next;
    cms_pkg::side_t b_side_next;

    assign ax = a_x_reg[31] ? 32'(~a_x_reg + 32'd1) : a_x_reg;
    assign ay = a_y_reg[31] ? 32'(~a_y_reg + 32'd1) : a_y_reg;
    assign az = a_z_reg[31] ? 32'(~a_z_reg + 32'd1) : a_z_reg;
    assign xs = {a_x_reg[31], a_x_reg};
    assign ys = {a_y_reg[31], a_y_reg};
    assign zs = {a_z_reg[31], a_z_reg};
    assign xn = 33'(33'd0 - xs);
    assign yn = 33'(33'd0 - ys);
    assign zn = 33'(33'd0 - zs);

    always_comb
    begin
        if (ax > ay && ax > az)
        begin
            ma_next = ax;
            tc_next = yn;
            if (!a_x_reg[31] && a_x_reg != 32'd0)
            begin
                cube_face = 3'd0;
                sc_next   = zn;
            end
            else
            begin
                cube_face = 3'd1;
                sc_next   = zs;
            end
        end
        else if (ay > az)
        begin
            ma_next = ay;
            sc_next = xs;
            if (!a_y_reg[31] && a_y_reg != 32'd0)
            begin
                cube_face = 3'd2;
                tc_next   = zs;
            end
            else
            begin
                cube_face = 3'd3;
                tc_next   = zn;
            end
        end
        else
        begin
            ma_next = az;
            tc_next = yn;
            if (!a_z_reg[31] && a_z_reg != 32'd0)
            begin
                cube_face = 3'd4;
                sc_next   = xs;
            end
            else
            begin
                cube_face = 3'd5;
                sc_next   = xn;
            end
        end

        b_side_next.mode        = a_mode_reg;
        b_side_next.face        = (a_mode_reg == cms_pkg::MODE_CUBE) ? cube_face : a_face_reg;
        b_side_next.texel_index = a_idx_reg;
        b_side_next.texel_data  = a_data_reg;
        b_side_next.cu          = cms_pkg::addr_coord({{2{a_u_reg[31]}}, a_u_reg}, clamp_reg);
        b_side_next.cv          = cms_pkg::addr_coord({{2{a_v_reg[31]}}, a_v_reg}, clamp_reg);
        b_side_next.zero_dir    = 1'b0;
    end

    logic           b_valid_reg;
    logic [31:0]    b_ma_reg;
    logic [32:0]    b_sc_reg;
    logic [32:0]    b_tc_reg;
    cms_pkg::side_t b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ma_reg   <= ma_next;
            b_sc_reg   <= sc_next;
            b_tc_reg   <= tc_next;
            b_side_reg <= b_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: offset the face coordinates into [0, 2*ma].
    // ------------------------------------------------------------------
    logic [33:0]    n0s_sum;
    logic [33:0]    n0t_sum;
    cms_pkg::side_t c_side_next;

    assign n0s_sum = {b_sc_reg[32], b_sc_reg} + {2'b00, b_ma_reg};
    assign n0t_sum = {b_tc_reg[32], b_tc_reg} + {2'b00, b_ma_reg};

    always_comb
    begin
        c_side_next          = b_side_reg;
        c_side_next.zero_dir = (b_ma_reg == 32'd0);
    end

    logic           c_valid_reg;
    logic [32:0]    c_n0s_reg;
    logic [32:0]    c_n0t_reg;
    logic [31:0]    c_ma_reg;
    cms_pkg::side_t c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_n0s_reg  <= n0s_sum[32:0];
            c_n0t_reg  <= n0t_sum[32:0];
            c_ma_reg   <= b_ma_reg;
            c_side_reg <= c_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline: q = floor((w + ma) * 65536 / (2 * ma)).
    // ------------------------------------------------------------------
    logic           d_valid;
    logic [16:0]    d_qs;
    logic [16:0]    d_qt;
    cms_pkg::side_t d_side;

    cms_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .n0_s      (c_n0s_reg),
        .n0_t      (c_n0t_reg),
        .ma        (c_ma_reg),
        .side_in   (c_side_reg),
        .out_valid (d_valid),
        .q_s       (d_qs),
        .q_t       (d_qt),
        .side_out  (d_side)
    );

    // ------------------------------------------------------------------
    // Stage P: face coordinates through the address mode. A zero
    // direction samples the face center.
    // ------------------------------------------------------------------
    logic [16:0]    s_coord;
    logic [16:0]    t_coord;
    cms_pkg::side_t p_side_next;

    always_comb
    begin
        if (d_side.zero_dir)
        begin
            s_coord = cms_pkg::HALF_Q16;
            t_coord = cms_pkg::HALF_Q16;
        end
        else
        begin
            s_coord = d_qs;
            t_coord = 17'(cms_pkg::ONE_Q16 - d_qt);
        end
        p_side_next = d_side;
        if (d_side.mode == cms_pkg::MODE_CUBE)
        begin
            p_side_next.cu = cms_pkg::addr_coord({17'd0, s_coord}, clamp_reg);
            p_side_next.cv = cms_pkg::addr_coord({17'd0, t_coord}, clamp_reg);
        end
    end

    logic           p_valid_reg;
    cms_pkg::side_t p_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= p_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage Q: column and row.
    // ------------------------------------------------------------------
    logic [SW+16:0] col_prod;
    logic [SW+16:0] row_prod;

    assign col_prod = (SW+17)'(SW'(weff - SW'(1))) * (SW+17)'(p_side_reg.cu);
    assign row_prod = (SW+17)'(SW'(heff - SW'(1))) * (SW+17)'(p_side_reg.cv);

    logic           q_valid_reg;
    logic [CW-1:0]  q_col_reg;
    logic [CW-1:0]  q_row_reg;
    cms_pkg::side_t q_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            q_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_col_reg  <= col_prod[CW+15:16];
            q_row_reg  <= row_prod[CW+15:16];
            q_side_reg <= p_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage R: linear index and the kind of memory access.
    // ------------------------------------------------------------------
    logic [CW+SW-1:0] row_base;
    logic [IW-1:0]    samp_idx;
    logic             is_write;
    logic             face_ok;
    logic             write_ok;

    assign row_base = (CW+SW)'(q_row_reg) * (CW+SW)'(weff);
    assign samp_idx = IW'(row_base + (CW+SW)'(q_col_reg));
    assign is_write = (q_side_reg.mode == cms_pkg::MODE_WRITE);
    assign face_ok  = 32'(q_side_reg.face) < 32'(FACE_COUNT);
    assign write_ok = face_ok && (32'(q_side_reg.texel_index) < 32'(AREA));

    logic          r_wr_reg;
    logic          r_rd_reg;
    logic          r_sample_reg;
    logic          r_missing_reg;
    logic [2:0]    r_face_reg;
    logic [IW-1:0] r_idx_reg;
    logic [11:0]   r_used_reg;
    logic [31:0]   r_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_wr_reg     <= 1'b0;
            r_rd_reg     <= 1'b0;
            r_sample_reg <= 1'b0;
        end
        else if (en)
        begin
            r_wr_reg     <= q_valid_reg && is_write && write_ok;
            r_rd_reg     <= q_valid_reg && !is_write && face_ok;
            r_sample_reg <= q_valid_reg && !is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_missing_reg <= !face_ok;
            r_face_reg    <= q_side_reg.face;
            r_idx_reg     <= is_write ? IW'(q_side_reg.texel_index) : samp_idx;
            r_used_reg    <= 12'(samp_idx);
            r_data_reg    <= q_side_reg.texel_data;
        end
    end

    // ------------------------------------------------------------------
    // Memory stage: one write or one read per cycle while the pipeline advances, in request order.
    // ------------------------------------------------------------------
    logic [DW-1:0] mem_addr;
    logic [31:0]   mem_rdata;

    assign mem_addr = DW'(32'(r_face_reg) * 32'(AREA) + 32'(r_idx_reg));

    cms_store #(
        .DEPTH (DEPTH),
        .AW    (DW)
    ) u_store (
        .clk   (clk),
        .wr_en (en && r_wr_reg),
        .rd_en (en && r_rd_reg),
        .addr  (mem_addr),
        .wdata (r_data_reg),
        .rdata (mem_rdata)
    );

    logic        g_missing_reg;
    logic [2:0]  g_face_reg;
    logic [11:0] g_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= r_sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_missing_reg <= r_missing_reg;
            g_face_reg    <= r_face_reg;
            g_used_reg    <= r_used_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register. A missing face reads as texel zero.
    // ------------------------------------------------------------------
    logic [47:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && g_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && g_valid_reg)
        begin
            out_data_reg <= {1'b0, g_used_reg, g_face_reg,
                             g_missing_reg ? 32'd0 : mem_rdata};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/cms_div.sv @@
// ----------------------------------------------------------------------------
// cms_div
// Pipelined restoring divider for the two cube face coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_div (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [32:0]     n0_s,
    input  wire logic [32:0]     n0_t,
    input  wire logic [31:0]     ma,
    input  wire cms_pkg::side_t  side_in,
    output logic                 out_valid,
    output logic [16:0]          q_s,
    output logic [16:0]          q_t,
    output cms_pkg::side_t       side_out
);

    localparam int N = cms_pkg::DIV_STEPS;

    // Each step computes floor(n0 * 2^15 / ma) one quotient bit further.
    logic                 v_reg  [N];
    logic [31:0]          rs_reg [N];
    logic [31:0]          rt_reg [N];
    logic [1:0]           ls_reg [N];
    logic [1:0]           lt_reg [N];
    logic [16:0]          qs_reg [N];
    logic [16:0]          qt_reg [N];
    logic [31:0]          ma_reg [N];
    cms_pkg::side_t       sd_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic           v_in;
        logic [31:0]    rs_in;
        logic [31:0]    rt_in;
        logic [1:0]     ls_in;
        logic [1:0]     lt_in;
        logic [16:0]    qs_in;
        logic [16:0]    qt_in;
        logic [31:0]    ma_in;
        cms_pkg::side_t sd_in;
        logic [32:0]    shs;
        logic [32:0]    sht;
        logic           ges;
        logic           get;
        logic [31:0]    rs_next;
        logic [31:0]    rt_next;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign rs_in = {1'b0, n0_s[32:2]};
            assign rt_in = {1'b0, n0_t[32:2]};
            assign ls_in = n0_s[1:0];
            assign lt_in = n0_t[1:0];
            assign qs_in = '0;
            assign qt_in = '0;
            assign ma_in = ma;
            assign sd_in = side_in;
        end else begin : g_later
            assign v_in  = v_reg[k-1];
            assign rs_in = rs_reg[k-1];
            assign rt_in = rt_reg[k-1];
            assign ls_in = ls_reg[k-1];
            assign lt_in = lt_reg[k-1];
            assign qs_in = qs_reg[k-1];
            assign qt_in = qt_reg[k-1];
            assign ma_in = ma_reg[k-1];
            assign sd_in = sd_reg[k-1];
        end

        assign shs     = {rs_in, ls_in[1]};
        assign sht     = {rt_in, lt_in[1]};
        assign ges     = shs >= {1'b0, ma_in};
        assign get     = sht >= {1'b0, ma_in};
        assign rs_next = ges ? 32'(shs - {1'b0, ma_in}) : shs[31:0];
        assign rt_next = get ? 32'(sht - {1'b0, ma_in}) : sht[31:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rs_reg[k] <= rs_next;
                rt_reg[k] <= rt_next;
                ls_reg[k] <= {ls_in[0], 1'b0};
                lt_reg[k] <= {lt_in[0], 1'b0};
                qs_reg[k] <= {qs_in[15:0], ges};
                qt_reg[k] <= {qt_in[15:0], get};
                ma_reg[k] <= ma_in;
                sd_reg[k] <= sd_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign q_s       = qs_reg[N-1];
    assign q_t       = qt_reg[N-1];
    assign side_out  = sd_reg[N-1];

endmodule

`default_nettype wire

@@ rtl/cms_store.sv @@
// ----------------------------------------------------------------------------
// cms_store
// Texel memory: one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_store #(
    parameter int DEPTH = 24576,
    parameter int AW    = 15
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] addr,
    input  wire logic [31:0]   wdata,
    output logic [31:0]        rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cms_check.sv @@
// ----------------------------------------------------------------------------
// cms_check
// Port-level checks of the cube map sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_check #(
    parameter int MAX_SIDE   = 64,
    parameter int FACE_COUNT = 6
) (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [1:0]   s_axis_tuser,
    input wire logic [207:0] s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [47:0]  m_axis_tdata,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [1:0]   cfg_index,
    input wire logic [6:0]   cfg_data
);

    localparam int AREA = MAX_SIDE * MAX_SIDE;

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result is shown in the first cycle out of reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A face beyond the store reads as texel zero.
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (32'(m_axis_tdata[34:32]) >= 32'(FACE_COUNT))
            |-> m_axis_tdata[31:0] == 32'd0)
        else $error("missing face returned a texel");

    // The reported index always lies inside one face; checked only for faces under 4096 texels.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (AREA >= 4096) || (32'(m_axis_tdata[46:35]) < 32'(AREA)))
        else $error("index outside the face");

endmodule

bind cubemap_nearest_texture_sampler cms_check #(
    .MAX_SIDE   (MAX_SIDE),
    .FACE_COUNT (FACE_COUNT)
) u_cms_check (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives texel writes, 2D face samples and cube direction samples into the
// cube map sampler, predicts each sampled texel and checks it on the result
// stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the predicted texel lookups and compares results against them.
class texel_scoreboard;
    logic [31:0] store [0:24575];
    bit          written [0:24575];
    int          fw;
    int          fh;
    bit          clamp;
    logic [31:0] exp_texel [$];
    logic [2:0]  exp_face [$];
    logic [11:0] exp_index [$];
    int          mismatches;

    function new();
        fw = 64;
        fh = 64;
        clamp = 0;
        mismatches = 0;
        for (int i = 0; i < 24576; i++) begin
            written[i] = 0;
            store[i] = '0;
        end
    endfunction

    function int side(input int r);
        if (r == 0) return 1;
        if (r > 64) return 64;
        return r;
    endfunction

    function longint wrap_coord(input longint c);
        if (clamp) begin
            if (c < 0) return 0;
            if (c > 65536) return 65536;
            return c;
        end
        return c & 64'hFFFF;
    endfunction

    // Row-major index that a sample at (u, v) lands on, for the current size.
    function int lookup_index(input longint u, input longint v);
        int w;
        int h;
        longint col;
        longint row;
        w = side(fw);
        h = side(fh);
        col = ((w - 1) * wrap_coord(u)) >>> 16;
        row = ((h - 1) * wrap_coord(v)) >>> 16;
        return int'(row * w + col);
    endfunction

    // Face and index that a sample request reads.
    function void locate(input cms_pkg::mode_t m, input logic [207:0] d,
                         output int f, output int idx);
        longint x;
        longint y;
        longint z;
        longint ax;
        longint ay;
        longint az;
        longint ma;
        longint sc;
        longint tc;
        longint s;
        longint t;
        if (m == cms_pkg::MODE_CUBE) begin
            x = longint'($signed(d[142:111]));
            y = longint'($signed(d[174:143]));
            z = longint'($signed(d[206:175]));
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            az = z < 0 ? -z : z;
            if (ax > ay && ax > az) begin
                ma = ax;
                if (x > 0) begin f = 0; sc = -z; tc = -y; end
                else begin f = 1; sc = z; tc = -y; end
            end else if (ay > az) begin
                ma = ay;
                if (y > 0) begin f = 2; sc = x; tc = z; end
                else begin f = 3; sc = x; tc = -z; end
            end else begin
                ma = az;
                if (z > 0) begin f = 4; sc = x; tc = -y; end
                else begin f = 5; sc = -x; tc = -y; end
            end
            if (ma == 0) begin
                s = 32768;
                t = 32768;
            end else begin
                s = ((sc + ma) <<< 16) / (2 * ma);
                t = 65536 - ((tc + ma) <<< 16) / (2 * ma);
            end
            idx = lookup_index(s, t);
        end else begin
            f = int'(d[2:0]);
            idx = lookup_index(longint'($signed(d[78:47])),
                               longint'($signed(d[110:79])));
        end
    endfunction

    // Notes an accepted request and records what it should return.
    function void note_request(input cms_pkg::mode_t m, input logic [207:0] d);
        int f;
        int idx;
        if (m == cms_pkg::MODE_WRITE) begin
            if (d[2:0] < 6) begin
                store[d[2:0] * 4096 + d[14:3]] = d[46:15];
                written[d[2:0] * 4096 + d[14:3]] = 1;
            end
        end else if (m == cms_pkg::MODE_FACE || m == cms_pkg::MODE_CUBE) begin
            locate(m, d, f, idx);
            exp_face.push_back(f[2:0]);
            exp_index.push_back(idx[11:0]);
            if (f < 6 && idx < 4096) exp_texel.push_back(store[f * 4096 + idx]);
            else exp_texel.push_back('0);
        end
    endfunction

    function void check_result(input logic [47:0] r);
        logic [31:0] et;
        logic [2:0]  ef;
        logic [11:0] ei;
        if (exp_texel.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", r);
            return;
        end
        et = exp_texel.pop_front();
        ef = exp_face.pop_front();
        ei = exp_index.pop_front();
        if (r[31:0] !== et || r[34:32] !== ef || r[46:35] !== ei) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected texel %h face %0d index %0d, got %h %0d %0d",
                         et, ef, ei, r[31:0], r[34:32], r[46:35]);
        end
    endfunction
endclass

module testbench;
    localparam int LATENCY = 25;
    localparam int STALL_LIMIT = 2000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser;
    logic [207:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [6:0]   cfg_data;

    texel_scoreboard texels;
    int  idle_cycles;
    bit  stimulus_done;

    cubemap_nearest_texture_sampler dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: random stalls, and every accepted texel is checked.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            texels.check_result(m_axis_tdata);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n || stimulus_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Sends one request. A sample whose texel has no value yet is preceded
    // by a write of that texel. The valid line stays high after acceptance
    // so that the next request can follow in the very next cycle.
    task automatic send_request(input cms_pkg::mode_t m, input logic [207:0] d);
        int gap;
        int f;
        int idx;
        if (m != cms_pkg::MODE_WRITE)
        begin
            texels.locate(m, d, f, idx);
            if (f < 6 && !texels.written[f * 4096 + idx])
                write_texel(f, idx, $urandom);
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= m;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        texels.note_request(m, d);
    endtask

    task automatic write_texel(input int face, input int idx, input logic [31:0] val);
        logic [207:0] d;
        d = '0;
        d[2:0] = face[2:0];
        d[14:3] = idx[11:0];
        d[46:15] = val;
        send_request(cms_pkg::MODE_WRITE, d);
    endtask

    task automatic face_sample(input int face, input logic [31:0] u, input logic [31:0] v);
        logic [207:0] d;
        d = '0;
        d[2:0] = face[2:0];
        d[14:3] = 12'($urandom);
        d[46:15] = $urandom;
        d[78:47] = u;
        d[110:79] = v;
        send_request(cms_pkg::MODE_FACE, d);
    endtask

    task automatic cube_sample(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        logic [207:0] d;
        d = '0;
        d[2:0] = 3'($urandom_range(0, 7));
        d[78:47] = $urandom;
        d[110:79] = $urandom;
        d[142:111] = x;
        d[174:143] = y;
        d[206:175] = z;
        send_request(cms_pkg::MODE_CUBE, d);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == cms_pkg::REG_FACE_WIDTH) texels.fw = int'(val);
        else if (idx == cms_pkg::REG_FACE_HEIGHT) texels.fh = int'(val);
        else if (idx == cms_pkg::REG_ADDRESS_MODE) texels.clamp = val[0];
        @(posedge clk);
    endtask

    // Waits until every sample has returned, then lets writes drain.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (texels.exp_texel.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Random coordinate: mostly near [0,1], sometimes any 32-bit value.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 65536);
            2: return $urandom_range(0, 196608) - 65536;
            default: return $urandom_range(0, 1) ? 32'd65536 : 32'd0;
        endcase
    endfunction

    initial
    begin
        logic [31:0] big;
        texels = new();
        stimulus_done = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of the coordinates, all faces, the repeat wrap rule only.
        write_texel(0, 0, 32'hFFFF_FFFF);
        write_texel(5, 4095, 32'h0000_0000);
        write_texel(7, 12, 32'h1234_5678);       // missing face, ignored
        face_sample(0, 32'h0000_0000, 32'h0000_0000);
        face_sample(5, 32'h0001_0000, 32'h0001_0000);
        face_sample(3, 32'h7FFF_FFFF, 32'h8000_0000);
        face_sample(6, 32'hFFFF_FFFF, 32'h0000_8000);  // missing face
        face_sample(7, 32'h0000_FFFF, 32'hFFFF_0000);
        cube_sample(32'h0001_0000, 0, 0);
        cube_sample(32'hFFFF_0000, 0, 0);
        cube_sample(0, 32'h0001_0000, 0);
        cube_sample(0, 32'hFFFF_0000, 0);
        cube_sample(0, 0, 32'h0001_0000);
        cube_sample(0, 0, 32'hFFFF_0000);
        cube_sample(0, 0, 0);                       // zero direction
        cube_sample(32'h0001_0000, 32'h0001_0000, 32'h0001_0000); // three-way tie
        cube_sample(32'h0001_0000, 32'hFFFF_0000, 0);              // x/y tie
        cube_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= 2'd3;                       // unknown kind, no result
        s_axis_tdata <= '1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        drain();

        // Random phases over several sizes and both wrap rules, extremes among them.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin
                    write_register(cms_pkg::REG_FACE_WIDTH, 7'd1);
                    write_register(cms_pkg::REG_FACE_HEIGHT, 7'd64);
                end
                1: begin
                    write_register(cms_pkg::REG_FACE_WIDTH, 7'd64);
                    write_register(cms_pkg::REG_FACE_HEIGHT, 7'd1);
                end
                2: begin
                    write_register(cms_pkg::REG_FACE_WIDTH, 7'd0);
                    write_register(cms_pkg::REG_FACE_HEIGHT, 7'd127);
                end
                default: begin
                    write_register(cms_pkg::REG_FACE_WIDTH, 7'($urandom_range(1, 64)));
                    write_register(cms_pkg::REG_FACE_HEIGHT, 7'($urandom_range(1, 64)));
                end
            endcase
            write_register(cms_pkg::REG_ADDRESS_MODE, 7'(phase[0]));
            for (int n = 0; n < 55; n++)
            begin
                case ($urandom_range(0, 5))
                    0: write_texel($urandom_range(0, 7), $urandom, $urandom);
                    1, 2: face_sample($urandom_range(0, 7), rand_coord(), rand_coord());
                    default: begin
                        big = $urandom;
                        cube_sample(($urandom_range(0, 1) ? big : rand_coord()),
                                    rand_coord(), rand_coord());
                    end
                endcase
            end
            drain();
        end

        stimulus_done = 1;
        if (texels.mismatches == 0 && texels.exp_texel.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
